// ===== rtl/core/yuv_color_convert_and_distance_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the YUV convert and distance block.
// ----------------------------------------------------------------------------
`ifndef YUV_COLOR_CONVERT_AND_DISTANCE_ASSERT_SVH
`define YUV_COLOR_CONVERT_AND_DISTANCE_ASSERT_SVH

// same-cycle implication
`define YUVCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define YUVCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/yuvcd_pkg.sv =====
// ----------------------------------------------------------------------------
// yuvcd_pkg
// Shared types and constants of the YUV convert and distance block.
// ----------------------------------------------------------------------------
package yuvcd_pkg;

   localparam int ChanWidth     = 16;
   localparam int WeightWidth   = 16;
   localparam int FuncWidth     = 2;
   localparam int DistWidth     = 16;
   localparam int ReqDataWidth  = 6 * ChanWidth;
   localparam int RspDataWidth  = 3 * ChanWidth + DistWidth;
   localparam int CsrAddrWidth  = 4;
   localparam int CsrDataWidth  = 32;
   localparam int FrontStages   = 5;
   localparam int RadicandWidth = 42;
   localparam int RootWidth     = RadicandWidth / 2;
   localparam int RemWidth      = RootWidth + 3;
   localparam int RoundWidth    = RootWidth + 1;

   localparam logic [FuncWidth-1:0] FuncRgbToYuv = 2'd0;
   localparam logic [FuncWidth-1:0] FuncYuvToRgb = 2'd1;
   localparam logic [FuncWidth-1:0] FuncDistance = 2'd2;

   localparam logic [WeightWidth-1:0]      WeightOne = 16'd4096;
   localparam logic signed [ChanWidth-1:0] UnitOne   = 16'sd16384;
   localparam logic [DistWidth-1:0]        DistMax   = 16'hFFFF;

   typedef enum logic [1:0] {
      RegLumaWeight = 2'd0,
      RegUWeight    = 2'd1,
      RegVWeight    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WeightWidth-1:0] luma;
      logic [WeightWidth-1:0] u;
      logic [WeightWidth-1:0] v;
   } weights_type;

   typedef struct packed {
      logic signed [ChanWidth-1:0] res_a;
      logic signed [ChanWidth-1:0] res_b;
      logic signed [ChanWidth-1:0] res_c;
      logic                        clamped;
   } side_type;

endpackage

// ===== rtl/core/yuv_color_convert_and_distance.sv =====
// ----------------------------------------------------------------------------
// yuv_color_convert_and_distance
// BT.601 RGB/YUV conversion and weighted YUV distance, one item per clock.
// ----------------------------------------------------------------------------
// Items arrive on the req stream: req_tuser carries the operation code and
// req_tdata the first and second colour triples. Each transfer yields exactly
// one transfer on the rsp stream: the three converted channels and the
// distance in rsp_tdata, the clamp flag in rsp_tuser.
// The datapath is 28 register stages long: input register, five stages of
// products and sums, 21 square root stages (one root bit each), and the
// output register. Throughput is one item per clock; the root stages set
// the length. When rsp_tready is low with a result waiting, the whole
// pipeline holds and req_tready drops in the same cycle; nothing is dropped
// or repeated. Reset clears all valid bits and loads every weight with 1.0
// (4096). The user must write weights over the csr port only while no item
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "yuv_color_convert_and_distance_assert.svh"

module yuv_color_convert_and_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // first_a, first_b, first_c, second_a, second_b, second_c
   input  logic [yuvcd_pkg::ReqDataWidth-1:0]  req_tdata,
   // func
   input  logic [yuvcd_pkg::FuncWidth-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // res_a, res_b, res_c, dist_res
   output logic [yuvcd_pkg::RspDataWidth-1:0]  rsp_tdata,
   // clamped
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [yuvcd_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [yuvcd_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [yuvcd_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import yuvcd_pkg::*;

   logic advance;

   logic                        in_valid_ff;
   logic [FuncWidth-1:0]        in_func_ff;
   logic signed [ChanWidth-1:0] in_first_a_ff, in_first_b_ff, in_first_c_ff;
   logic signed [ChanWidth-1:0] in_second_a_ff, in_second_b_ff, in_second_c_ff;
   logic [FrontStages-1:0]      stage_valid_ff;

   weights_type                 weights;
   logic signed [ChanWidth-1:0] conv_res_a, conv_res_b, conv_res_c;
   logic                        conv_clamped;
   logic [RadicandWidth-1:0]    sum_sq;
   side_type                    conv_side;

   logic                        sqrt_valid;
   logic [RootWidth-1:0]        sqrt_root;
   side_type                    sqrt_side;

   logic [RoundWidth-1:0]       root_round;
   logic [RoundWidth-3:0]       dist_full;
   logic [DistWidth-1:0]        dist_in;

   logic                        rsp_valid_ff;
   logic signed [ChanWidth-1:0] rsp_res_a_ff, rsp_res_b_ff, rsp_res_c_ff;
   logic [DistWidth-1:0]        rsp_dist_ff;
   logic                        rsp_clamped_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         in_valid_ff    <= req_tvalid;
         stage_valid_ff <= {stage_valid_ff[FrontStages-2:0], in_valid_ff};
         rsp_valid_ff   <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_func_ff     <= req_tuser;
         in_first_a_ff  <= req_tdata[0*ChanWidth +: ChanWidth];
         in_first_b_ff  <= req_tdata[1*ChanWidth +: ChanWidth];
         in_first_c_ff  <= req_tdata[2*ChanWidth +: ChanWidth];
         in_second_a_ff <= req_tdata[3*ChanWidth +: ChanWidth];
         in_second_b_ff <= req_tdata[4*ChanWidth +: ChanWidth];
         in_second_c_ff <= req_tdata[5*ChanWidth +: ChanWidth];
      end
   end

   yuvcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .weights     (weights)
   );

   yuvcd_conv u_conv (
      .clock   (clock),
      .advance (advance),
      .func    (in_func_ff),
      .chan_a  (in_first_a_ff),
      .chan_b  (in_first_b_ff),
      .chan_c  (in_first_c_ff),
      .res_a   (conv_res_a),
      .res_b   (conv_res_b),
      .res_c   (conv_res_c),
      .clamped (conv_clamped)
   );

   yuvcd_dist u_dist (
      .clock    (clock),
      .advance  (advance),
      .func     (in_func_ff),
      .first_a  (in_first_a_ff),
      .first_b  (in_first_b_ff),
      .first_c  (in_first_c_ff),
      .second_a (in_second_a_ff),
      .second_b (in_second_b_ff),
      .second_c (in_second_c_ff),
      .weights  (weights),
      .sum_sq   (sum_sq)
   );

   assign conv_side = '{res_a: conv_res_a, res_b: conv_res_b, res_c: conv_res_c,
                        clamped: conv_clamped};

   yuvcd_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (stage_valid_ff[FrontStages-1]),
      .in_radicand (sum_sq),
      .in_side     (conv_side),
      .out_valid   (sqrt_valid),
      .out_root    (sqrt_root),
      .out_side    (sqrt_side)
   );

   assign root_round = {1'b0, sqrt_root} + RoundWidth'(2);
   assign dist_full  = root_round[RoundWidth-1:2];
   assign dist_in    = (|dist_full[RoundWidth-3:DistWidth]) ? DistMax
                                                             : dist_full[DistWidth-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_res_a_ff   <= sqrt_side.res_a;
         rsp_res_b_ff   <= sqrt_side.res_b;
         rsp_res_c_ff   <= sqrt_side.res_c;
         rsp_clamped_ff <= sqrt_side.clamped;
         rsp_dist_ff    <= dist_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dist_ff, rsp_res_c_ff, rsp_res_b_ff, rsp_res_a_ff};
   assign rsp_tuser  = rsp_clamped_ff;

   `YUVCD_ASSERT_NEXT(a_take_enters, clock, reset, req_tvalid && req_tready, in_valid_ff, "transfer did not enter the pipeline")
   `YUVCD_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid_ff && !rsp_tready, $stable(stage_valid_ff) && $stable(sqrt_valid), "pipeline moved during stall")
   `YUVCD_ASSERT_SAME(a_dist_alone, clock, reset, rsp_valid_ff && (rsp_dist_ff != '0), (rsp_res_a_ff == '0) && (rsp_res_b_ff == '0) && (rsp_res_c_ff == '0) && !rsp_clamped_ff, "distance result with colour fields set")
   `YUVCD_ASSERT_SAME(a_clamp_range, clock, reset, rsp_valid_ff && rsp_clamped_ff, !rsp_res_a_ff[ChanWidth-1] && (rsp_res_a_ff <= UnitOne) && !rsp_res_b_ff[ChanWidth-1] && (rsp_res_b_ff <= UnitOne) && !rsp_res_c_ff[ChanWidth-1] && (rsp_res_c_ff <= UnitOne), "clamped result outside unit range")

endmodule

// ===== rtl/core/yuvcd_csr.sv =====
// ----------------------------------------------------------------------------
// yuvcd_csr
// Register file for the distance weights behind a simple APB-style port.
// ----------------------------------------------------------------------------
module yuvcd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [yuvcd_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [yuvcd_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [yuvcd_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                              csr_pready,
   output yuvcd_pkg::weights_type            weights
);
   import yuvcd_pkg::*;

   csr_index_type index;
   logic          write_en;
   weights_type   weights_ff;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign weights    = weights_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff <= '{luma: WeightOne, u: WeightOne, v: WeightOne};
      end else if (write_en) begin
         unique case (index)
            RegLumaWeight: weights_ff.luma <= csr_pwdata[WeightWidth-1:0];
            RegUWeight:    weights_ff.u    <= csr_pwdata[WeightWidth-1:0];
            RegVWeight:    weights_ff.v    <= csr_pwdata[WeightWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         RegLumaWeight: csr_prdata = CsrDataWidth'(weights_ff.luma);
         RegUWeight:    csr_prdata = CsrDataWidth'(weights_ff.u);
         RegVWeight:    csr_prdata = CsrDataWidth'(weights_ff.v);
         default:       csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/yuvcd_conv.sv =====
// ----------------------------------------------------------------------------
// yuvcd_conv
// Five-stage BT.601 RGB to YUV and YUV to RGB conversion datapath.
// ----------------------------------------------------------------------------
module yuvcd_conv (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [yuvcd_pkg::FuncWidth-1:0]     func,
   input  logic signed [yuvcd_pkg::ChanWidth-1:0] chan_a,
   input  logic signed [yuvcd_pkg::ChanWidth-1:0] chan_b,
   input  logic signed [yuvcd_pkg::ChanWidth-1:0] chan_c,
   output logic signed [yuvcd_pkg::ChanWidth-1:0] res_a,
   output logic signed [yuvcd_pkg::ChanWidth-1:0] res_b,
   output logic signed [yuvcd_pkg::ChanWidth-1:0] res_c,
   output logic                                clamped
);
   import yuvcd_pkg::*;

   localparam int ProdWidth = 36;
   localparam int WideWidth = 52;
   localparam int FracShift = 16;
   localparam int WideShift = 32;

   localparam logic signed [ProdWidth-1:0] CoefYr = 36'sd19595;
   localparam logic signed [ProdWidth-1:0] CoefYg = 36'sd38470;
   localparam logic signed [ProdWidth-1:0] CoefYb = 36'sd7471;
   localparam logic signed [ProdWidth-1:0] CoefRv = 36'sd74700;
   localparam logic signed [ProdWidth-1:0] CoefGu = 36'sd25864;
   localparam logic signed [ProdWidth-1:0] CoefGv = 36'sd38050;
   localparam logic signed [ProdWidth-1:0] CoefBu = 36'sd133176;
   localparam logic signed [ProdWidth-1:0] Half16 = 36'sd32768;
   localparam logic signed [WideWidth-1:0] CoefU  = 52'sd32244;
   localparam logic signed [WideWidth-1:0] CoefV  = 52'sd57475;
   localparam logic signed [WideWidth-1:0] Half32 = 52'sd2147483648;
   localparam logic signed [WideWidth-1:0] SatHi  = 52'sd32767;
   localparam logic signed [WideWidth-1:0] SatLo  = -52'sd32768;

   function automatic logic signed [ChanWidth-1:0] sat_s16(
      input logic signed [WideWidth-1:0] v);
      logic signed [ChanWidth-1:0] r;
      if (v > SatHi) begin
         r = SatHi[ChanWidth-1:0];
      end else if (v < SatLo) begin
         r = SatLo[ChanWidth-1:0];
      end else begin
         r = v[ChanWidth-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [ChanWidth-1:0] clamp_unit(
      input logic signed [ProdWidth-1:0] v);
      logic signed [ChanWidth-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > UnitOne) begin
         r = UnitOne;
      end else begin
         r = v[ChanWidth-1:0];
      end
      return r;
   endfunction

   function automatic logic out_of_unit(input logic signed [ProdWidth-1:0] v);
      return (v < 0) || (v > UnitOne);
   endfunction

   // stage 1: coefficient products
   logic signed [ProdWidth-1:0] a_ext, b_ext, c_ext;
   logic signed [ProdWidth-1:0] py_r_ff, py_g_ff, py_b_ff;
   logic signed [ProdWidth-1:0] pr_v_ff, pg_u_ff, pg_v_ff, pb_u_ff;
   logic signed [ChanWidth-1:0] a1_ff, c1_ff;
   logic [FuncWidth-1:0]        func1_ff;

   assign a_ext = ProdWidth'(chan_a);
   assign b_ext = ProdWidth'(chan_b);
   assign c_ext = ProdWidth'(chan_c);

   always_ff @(posedge clock) begin
      if (advance) begin
         py_r_ff  <= a_ext * CoefYr;
         py_g_ff  <= b_ext * CoefYg;
         py_b_ff  <= c_ext * CoefYb;
         pr_v_ff  <= c_ext * CoefRv;
         pg_u_ff  <= b_ext * CoefGu;
         pg_v_ff  <= c_ext * CoefGv;
         pb_u_ff  <= b_ext * CoefBu;
         a1_ff    <= chan_a;
         c1_ff    <= chan_c;
         func1_ff <= func;
      end
   end

   // stage 2: sums
   logic signed [ProdWidth-1:0] a_hi1;
   logic signed [ProdWidth-1:0] y30_in, r_acc_in, g_acc_in, b_acc_in;
   logic signed [ProdWidth-1:0] y30_ff, r_acc_ff, g_acc_ff, b_acc_ff;
   logic signed [ChanWidth-1:0] a2_ff, c2_ff;
   logic [FuncWidth-1:0]        func2_ff;

   assign a_hi1    = ProdWidth'(a1_ff) <<< FracShift;
   assign y30_in   = py_r_ff + py_g_ff + py_b_ff;
   assign r_acc_in = a_hi1 + pr_v_ff + Half16;
   assign g_acc_in = a_hi1 - pg_u_ff - pg_v_ff + Half16;
   assign b_acc_in = a_hi1 + pb_u_ff + Half16;

   always_ff @(posedge clock) begin
      if (advance) begin
         y30_ff   <= y30_in;
         r_acc_ff <= r_acc_in;
         g_acc_ff <= g_acc_in;
         b_acc_ff <= b_acc_in;
         a2_ff    <= a1_ff;
         c2_ff    <= c1_ff;
         func2_ff <= func1_ff;
      end
   end

   // stage 3: luma rounding, chroma differences, RGB clamp
   logic signed [ProdWidth-1:0] a_hi2, c_hi2, y_rnd, r_sh, g_sh, b_sh;
   logic signed [ChanWidth-1:0] y3_in;
   logic signed [ProdWidth-1:0] u_diff_in, v_diff_in;
   logic                        hit3_in;
   logic signed [ChanWidth-1:0] y3_ff, r3_ff, g3_ff, b3_ff;
   logic signed [ProdWidth-1:0] u_diff_ff, v_diff_ff;
   logic                        hit3_ff;
   logic [FuncWidth-1:0]        func3_ff;

   assign a_hi2     = ProdWidth'(a2_ff) <<< FracShift;
   assign c_hi2     = ProdWidth'(c2_ff) <<< FracShift;
   assign y_rnd     = (y30_ff + Half16) >>> FracShift;
   assign y3_in     = sat_s16(WideWidth'(y_rnd));
   assign u_diff_in = c_hi2 - y30_ff;
   assign v_diff_in = a_hi2 - y30_ff;
   assign r_sh      = r_acc_ff >>> FracShift;
   assign g_sh      = g_acc_ff >>> FracShift;
   assign b_sh      = b_acc_ff >>> FracShift;
   assign hit3_in   = out_of_unit(r_sh) || out_of_unit(g_sh) || out_of_unit(b_sh);

   always_ff @(posedge clock) begin
      if (advance) begin
         y3_ff     <= y3_in;
         u_diff_ff <= u_diff_in;
         v_diff_ff <= v_diff_in;
         r3_ff     <= clamp_unit(r_sh);
         g3_ff     <= clamp_unit(g_sh);
         b3_ff     <= clamp_unit(b_sh);
         hit3_ff   <= hit3_in;
         func3_ff  <= func2_ff;
      end
   end

   // stage 4: chroma scaling
   logic signed [WideWidth-1:0] mu_ff, mv_ff;
   logic signed [ChanWidth-1:0] y4_ff, r4_ff, g4_ff, b4_ff;
   logic                        hit4_ff;
   logic [FuncWidth-1:0]        func4_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         mu_ff    <= WideWidth'(u_diff_ff) * CoefU;
         mv_ff    <= WideWidth'(v_diff_ff) * CoefV;
         y4_ff    <= y3_ff;
         r4_ff    <= r3_ff;
         g4_ff    <= g3_ff;
         b4_ff    <= b3_ff;
         hit4_ff  <= hit3_ff;
         func4_ff <= func3_ff;
      end
   end

   // stage 5: chroma rounding and result select
   logic signed [WideWidth-1:0] u_rnd, v_rnd;
   logic signed [ChanWidth-1:0] res_a_in, res_b_in, res_c_in;
   logic                        clamped_in;
   logic signed [ChanWidth-1:0] res_a_ff, res_b_ff, res_c_ff;
   logic                        clamped_ff;

   assign u_rnd = (mu_ff + Half32) >>> WideShift;
   assign v_rnd = (mv_ff + Half32) >>> WideShift;

   always_comb begin
      case (func4_ff)
         FuncRgbToYuv: begin
            res_a_in   = y4_ff;
            res_b_in   = sat_s16(u_rnd);
            res_c_in   = sat_s16(v_rnd);
            clamped_in = 1'b0;
         end
         FuncYuvToRgb: begin
            res_a_in   = r4_ff;
            res_b_in   = g4_ff;
            res_c_in   = b4_ff;
            clamped_in = hit4_ff;
         end
         default: begin
            res_a_in   = '0;
            res_b_in   = '0;
            res_c_in   = '0;
            clamped_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_a_ff   <= res_a_in;
         res_b_ff   <= res_b_in;
         res_c_ff   <= res_c_in;
         clamped_ff <= clamped_in;
      end
   end

   assign res_a   = res_a_ff;
   assign res_b   = res_b_ff;
   assign res_c   = res_c_ff;
   assign clamped = clamped_ff;

endmodule

// ===== rtl/core/yuvcd_dist.sv =====
// ----------------------------------------------------------------------------
// yuvcd_dist
// Five-stage sum of squared weighted YUV differences, one lane per channel.
// ----------------------------------------------------------------------------
module yuvcd_dist (
   input  logic                                   clock,
   input  logic                                   advance,
   input  logic [yuvcd_pkg::FuncWidth-1:0]        func,
   input  logic signed [yuvcd_pkg::ChanWidth-1:0] first_a,
   input  logic signed [yuvcd_pkg::ChanWidth-1:0] first_b,
   input  logic signed [yuvcd_pkg::ChanWidth-1:0] first_c,
   input  logic signed [yuvcd_pkg::ChanWidth-1:0] second_a,
   input  logic signed [yuvcd_pkg::ChanWidth-1:0] second_b,
   input  logic signed [yuvcd_pkg::ChanWidth-1:0] second_c,
   input  yuvcd_pkg::weights_type                 weights,
   output logic [yuvcd_pkg::RadicandWidth-1:0]    sum_sq
);
   import yuvcd_pkg::*;

   localparam int Lanes     = 3;
   localparam int DiffWidth = ChanWidth + 1;
   localparam int ProdWidth = DiffWidth + WeightWidth + 1;
   localparam int ErrWidth  = 22;
   localparam int SqWidth   = 2 * ErrWidth;
   localparam int WeightFrac = 12;
   localparam logic signed [ProdWidth-1:0] Round12 = 34'sd2048;

   logic signed [ChanWidth-1:0]   first_lane  [Lanes];
   logic signed [ChanWidth-1:0]   second_lane [Lanes];
   logic [WeightWidth-1:0]        weight_lane [Lanes];
   logic signed [DiffWidth-1:0]   diff_ff     [Lanes];
   logic signed [ProdWidth-1:0]   prod_ff     [Lanes];
   logic signed [ErrWidth-1:0]    err_ff      [Lanes];
   logic [RadicandWidth-1:0]      sq_ff       [Lanes];
   logic [FuncWidth-1:0]          func1_ff, func2_ff, func3_ff, func4_ff;
   logic [RadicandWidth-1:0]      sum_in, sum_ff;

   assign first_lane[0]  = first_a;
   assign first_lane[1]  = first_b;
   assign first_lane[2]  = first_c;
   assign second_lane[0] = second_a;
   assign second_lane[1] = second_b;
   assign second_lane[2] = second_c;
   assign weight_lane[0] = weights.luma;
   assign weight_lane[1] = weights.u;
   assign weight_lane[2] = weights.v;

   for (genvar i = 0; i < Lanes; i++) begin : g_lane
      logic signed [ProdWidth-1:0] prod_in;
      logic signed [ProdWidth-1:0] err_wide;
      logic signed [SqWidth-1:0]   err_ext;
      logic signed [SqWidth-1:0]   sq_full;

      assign prod_in  = ProdWidth'(diff_ff[i]) * $signed({1'b0, weight_lane[i]});
      assign err_wide = (prod_ff[i] + Round12) >>> WeightFrac;
      assign err_ext  = SqWidth'(err_ff[i]);
      assign sq_full  = err_ext * err_ext;

      always_ff @(posedge clock) begin
         if (advance) begin
            diff_ff[i] <= DiffWidth'(second_lane[i]) - DiffWidth'(first_lane[i]);
            prod_ff[i] <= prod_in;
            err_ff[i]  <= err_wide[ErrWidth-1:0];
            sq_ff[i]   <= sq_full[RadicandWidth-1:0];
         end
      end
   end

   assign sum_in = (func4_ff == FuncDistance) ? (sq_ff[0] + sq_ff[1] + sq_ff[2]) : '0;

   always_ff @(posedge clock) begin
      if (advance) begin
         func1_ff <= func;
         func2_ff <= func1_ff;
         func3_ff <= func2_ff;
         func4_ff <= func3_ff;
         sum_ff   <= sum_in;
      end
   end

   assign sum_sq = sum_ff;

endmodule

// ===== rtl/core/yuvcd_sqrt.sv =====
// ----------------------------------------------------------------------------
// yuvcd_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module yuvcd_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [yuvcd_pkg::RadicandWidth-1:0] in_radicand,
   input  yuvcd_pkg::side_type                 in_side,
   output logic                                out_valid,
   output logic [yuvcd_pkg::RootWidth-1:0]     out_root,
   output yuvcd_pkg::side_type                 out_side
);
   import yuvcd_pkg::*;

   logic [RootWidth-1:0]     valid_ff;
   logic [RootWidth-1:0]     root_ff [RootWidth];
   side_type                 side_ff [RootWidth];
   logic [RemWidth-1:0]      rem_ff  [RootWidth-1];
   logic [RadicandWidth-1:0] rad_ff  [RootWidth-1];

   for (genvar k = 0; k < RootWidth; k++) begin : g_step
      logic [RemWidth-1:0]      rem_prev;
      logic [RootWidth-1:0]     root_prev;
      logic [RadicandWidth-1:0] rad_prev;
      logic                     valid_prev;
      side_type                 side_prev;
      logic [RemWidth-1:0]      rem_shift;
      logic [RemWidth-1:0]      trial;
      logic                     fits;

      if (k == 0) begin : g_first
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = in_radicand;
         assign valid_prev = in_valid;
         assign side_prev  = in_side;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign valid_prev = valid_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      assign rem_shift = {rem_prev[RemWidth-3:0], rad_prev[RadicandWidth-1 -: 2]};
      assign trial     = {1'b0, root_prev, 2'b01};
      assign fits      = rem_shift >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            root_ff[k] <= {root_prev[RootWidth-2:0], fits};
            side_ff[k] <= side_prev;
         end
      end

      if (k < RootWidth - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= fits ? (rem_shift - trial) : rem_shift;
               rad_ff[k] <= rad_prev << 2;
            end
         end
      end
   end

   assign out_valid = valid_ff[RootWidth-1];
   assign out_root  = root_ff[RootWidth-1];
   assign out_side  = side_ff[RootWidth-1];

endmodule
